@@ sv/arpc_pkg.sv @@
// Package with shared types, codes and defaults of the ARP cache table.
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int IP_W = 32;
    localparam int MAC_W = 48;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = IP_W + MAC_W;
    localparam int M_DATA_W = MAC_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_PRESENT  = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_HIT      = 3'd3,
        STAT_MISS     = 3'd4,
        STAT_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } entry_t;

endpackage

`default_nettype wire

@@ sv/arp_cache_table.sv @@
// ARP cache table: IPv4 to hardware address map held in a slot memory.
//
// The input stream carries one command per beat: s_tuser selects learn,
// lookup or clear, and s_tdata holds the IPv4 and hardware addresses.
// Every input beat produces exactly one output beat: m_tuser carries the
// status and m_tdata the stored hardware address on a lookup hit.
// Learned entries fill the slot memory in arrival order; slots below the
// fill count are the valid ones, so a clear only resets that count.
// A learn or lookup scans the occupied slots through the registered memory
// read port, one slot per cycle; a clear or an unused code goes straight
// from acceptance to the finish state.
// The scan of the memory sets the rate: one item is worked on at a time.
// The result sits in an output register, so a new beat is accepted while
// an earlier result still waits. When the receiver stalls, a second result
// waits in the finish state and input acceptance stops until it moves.
// Reset empties the table and the output register at once; no clearing
// pass over the memory is needed.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: ip_addr[31:0], hw_addr[79:32].
    input  wire logic [arpc_pkg::S_DATA_W-1:0] s_tdata,
    // Fields from bit 0: command[1:0].
    input  wire logic [arpc_pkg::CMD_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // Fields from bit 0: mac_out[47:0].
    output logic [arpc_pkg::M_DATA_W-1:0]      m_tdata,
    // Fields from bit 0: status[2:0].
    output logic [arpc_pkg::STATUS_W-1:0]      m_tuser
);

    import arpc_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IP_W-1:0]     ip_reg, ip_next;
    logic [MAC_W-1:0]    mac_reg, mac_next;
    status_t             res_status_reg, res_status_next;
    logic [MAC_W-1:0]    res_mac_reg, res_mac_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [MAC_W-1:0]    out_mac_reg, out_mac_next;

    entry_t              mem [ENTRIES];
    entry_t              rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic                match;
    logic                more;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mac_reg;
    assign m_tuser  = out_status_reg;

    assign more    = (issue_reg < fill_reg);
    assign rd_en   = (state_reg == ST_SCAN) && more;
    assign rd_addr = issue_reg[AW-1:0];
    assign match   = cmp_vld_reg && (rd_data_reg.ip == ip_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= '{ip: ip_reg, mac: mac_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmd_next        = cmd_reg;
        ip_next         = ip_reg;
        mac_next        = mac_reg;
        res_status_next = res_status_reg;
        res_mac_next    = res_mac_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_mac_next    = out_mac_reg;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = s_tuser;
                    ip_next      = s_tdata[IP_W-1:0];
                    mac_next     = s_tdata[S_DATA_W-1:IP_W];
                    res_mac_next = '0;
                    issue_next   = '0;
                    unique case (s_tuser)
                        CMD_LEARN, CMD_LOOKUP:
                        begin
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            fill_next       = '0;
                            res_status_next = STAT_CLEARED;
                            state_next      = ST_DONE;
                        end
                        default:
                        begin
                            res_status_next = STAT_MISS;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_DONE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_status_next = STAT_HIT;
                        res_mac_next    = rd_data_reg.mac;
                    end
                    else
                    begin
                        res_status_next = STAT_PRESENT;
                    end
                end
                else if (!more)
                begin
                    state_next = ST_DONE;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_status_next = STAT_MISS;
                    end
                    else if (fill_reg >= FULL_COUNT)
                    begin
                        res_status_next = STAT_FULL;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        fill_next       = fill_reg + 1'b1;
                        res_status_next = STAT_INSERTED;
                    end
                end
                else
                begin
                    issue_next   = issue_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_mac_next    = res_mac_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            issue_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_MISS;
            out_mac_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            issue_reg      <= issue_next;
            cmp_vld_reg    <= cmp_vld_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_mac_reg    <= out_mac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ip_reg         <= ip_next;
        mac_reg        <= mac_next;
        res_status_reg <= res_status_next;
        res_mac_reg    <= res_mac_next;
    end

endmodule

`default_nettype wire

@@ sv/arpc_checker.sv @@
// Port checker for the ARP cache table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module arpc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [arpc_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [arpc_pkg::STATUS_W-1:0] m_tuser
);

    import arpc_pkg::*;

    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("Output beat is valid during reset.");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled output beat changed.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= STATUS_W'(STAT_CLEARED)))
        else $error("Output status code is out of range.");

    a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != STATUS_W'(STAT_HIT)) |-> (m_tdata == '0))
        else $error("Hardware address is nonzero on a result other than a hit.");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (.*);

`default_nettype wire
